### design/prcm_pkg.sv
// prcm_pkg: shared types and fixed field widths for the product-rule cluster merge.
// Used by product_rule_cluster_merge; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prcm_pkg;

    // fixed widths of the interface fields
    localparam int END_W      = 12;
    localparam int CFG_W      = 13;
    localparam int IDX_W      = 6;
    localparam int SIZE_OUT_W = 13;
    localparam int PROD_OUT_W = 25;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_RD,
        S_FIND_STEP,
        S_COMP_RD,
        S_COMP_STEP,
        S_SIZE_A,
        S_SIZE_B,
        S_SIZE_GET,
        S_MUL,
        S_PICK,
        S_COMMIT,
        S_UNION
    } t_state;

    // which endpoint the root walker is working on
    typedef enum logic {
        PH_A,
        PH_B
    } t_phase;

endpackage

`default_nettype wire

### design/product_rule_cluster_merge.sv
// product_rule_cluster_merge: union-find forest that keeps the minimum size-product
// candidate bond of each run and adds it on the last candidate.
// Depends on prcm_pkg and prcm_ram (parent links and cluster sizes).
//
//   channel | direction | handshake              | fields
//   --------+-----------+------------------------+------------------------------------------
//   in      | to block  | i_in_valid / o_in_stall | i_end_a, i_end_b, i_last_candidate
//   out     | from block| o_out_valid / i_out_stall| o_chosen_index, o_merged, o_joined_size,
//           |           |                        | o_largest_size, o_chosen_product
//   cfg     | to block  | i_cfg_we               | i_node_count
//
// A candidate beat runs two root walks (find pass, then compression pass), one step per
// cycle through the parent memory's single read port, then reads both cluster sizes,
// multiplies them and keeps the smaller product. A last candidate adds the commit: two
// more walks, then the union. After reset and after every node_count write the block
// runs a clearing pass over both memories and holds o_in_stall high meanwhile.
// A result waits in the output register; only the union step waits on i_out_stall.
`timescale 1ns / 1ps
`default_nettype none

module product_rule_cluster_merge #(
    parameter int MAX_NODES      = 4096,
    parameter int MAX_CANDIDATES = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [prcm_pkg::CFG_W-1:0]      i_node_count,
    // candidate input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [prcm_pkg::END_W-1:0]      i_end_a,
    input  wire logic [prcm_pkg::END_W-1:0]      i_end_b,
    input  wire logic                            i_last_candidate,
    // result output
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [prcm_pkg::IDX_W-1:0]           o_chosen_index,
    output logic                                 o_merged,
    output logic [prcm_pkg::SIZE_OUT_W-1:0]      o_joined_size,
    output logic [prcm_pkg::SIZE_OUT_W-1:0]      o_largest_size,
    output logic [prcm_pkg::PROD_OUT_W-1:0]      o_chosen_product
);

    // node index, cluster size and product widths
    localparam int NW  = $clog2(MAX_NODES);
    localparam int SW  = $clog2(MAX_NODES + 1);
    localparam int PW  = 2 * SW;
    localparam int RPW = $clog2(MAX_CANDIDATES + 1);
    localparam int BPW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int XW  = (SW > prcm_pkg::END_W) ? SW : prcm_pkg::END_W;
    localparam int CFW = (SW > prcm_pkg::CFG_W) ? SW : prcm_pkg::CFG_W;
    localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

    // control registers
    prcm_pkg::t_state r_state, n_state;
    prcm_pkg::t_phase r_phase, n_phase;
    logic             r_merge, n_merge;
    logic [NW-1:0]    r_clr, n_clr;
    logic [SW-1:0]    r_node_cnt, n_node_cnt;
    logic [SW-1:0]    r_largest, n_largest;
    logic [RPW-1:0]   r_run_pos, n_run_pos;
    logic [BPW-1:0]   r_best_pos, n_best_pos;
    logic             r_out_valid, n_out_valid;

    // datapath registers
    logic [NW-1:0]    r_a, n_a, r_b, n_b;
    logic             r_last, n_last;
    logic [NW-1:0]    r_start, n_start, r_cur, n_cur;
    logic [NW-1:0]    r_root_a, n_root_a, r_root_b, n_root_b;
    logic [SW-1:0]    r_size_a, n_size_a, r_size_b, n_size_b;
    logic [PW-1:0]    r_prod, n_prod;
    logic [NW-1:0]    r_best_a, n_best_a, r_best_b, n_best_b;
    logic [PW-1:0]    r_best_prod, n_best_prod;
    logic [BPW-1:0]   r_out_idx, n_out_idx;
    logic             r_out_merged, n_out_merged;
    logic [SW-1:0]    r_out_joined, n_out_joined;
    logic [SW-1:0]    r_out_largest, n_out_largest;
    logic [PW-1:0]    r_out_prod, n_out_prod;

    // memory ports
    logic             par_we, cnt_we;
    logic [NW-1:0]    par_waddr, par_wdata, par_raddr, par_rd;
    logic [NW-1:0]    cnt_waddr, cnt_raddr;
    logic [SW-1:0]    cnt_wdata, cnt_rd;

    // shared helpers
    logic             in_acc, out_free, find_hit, comp_end, walk_done, take_cand;
    logic [NW-1:0]    root_cur, node_b_sel, clip_a, clip_b;
    logic [XW-1:0]    ext_a, ext_b, ext_lim;
    logic [CFW-1:0]   cfg_val;
    logic [SW-1:0]    cfg_sat, size_sum;

    // parent links and cluster sizes
    prcm_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_parent (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (par_raddr),
        .o_rdata (par_rd)
    );

    prcm_ram #(.DEPTH(MAX_NODES), .WIDTH(SW)) u_size (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rd)
    );

    // handshake
    assign o_in_stall = (r_state != prcm_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // endpoint saturation to node_count - 1
    assign ext_a   = XW'(i_end_a);
    assign ext_b   = XW'(i_end_b);
    assign ext_lim = XW'(r_node_cnt);
    assign clip_a  = (ext_a >= ext_lim) ? NW'(r_node_cnt - SW'(1)) : NW'(ext_a);
    assign clip_b  = (ext_b >= ext_lim) ? NW'(r_node_cnt - SW'(1)) : NW'(ext_b);

    // node_count saturation to 1..MAX_NODES
    assign cfg_val = CFW'(i_node_count);
    always_comb begin
        if (cfg_val == '0) begin
            cfg_sat = SW'(1);
        end else if (cfg_val > CFW'(MAX_NODES)) begin
            cfg_sat = SW'(MAX_NODES);
        end else begin
            cfg_sat = SW'(cfg_val);
        end
    end

    // root walker conditions
    assign take_cand  = (r_run_pos < RPW'(MAX_CANDIDATES));
    assign root_cur   = (r_phase == prcm_pkg::PH_A) ? r_root_a : r_root_b;
    assign node_b_sel = r_merge ? r_best_b : r_b;
    assign find_hit   = (par_rd == r_cur);
    assign comp_end   = (r_cur == root_cur);
    assign walk_done  = ((r_state == prcm_pkg::S_FIND_STEP) && find_hit && (r_cur == r_start))
                     || ((r_state == prcm_pkg::S_COMP_STEP) && comp_end);
    assign size_sum   = r_size_a + r_size_b;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prcm_pkg::S_CLEAR: begin
                if (r_clr == LAST_NODE) n_state = prcm_pkg::S_IDLE;
            end
            prcm_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (take_cand)             n_state = prcm_pkg::S_FIND_RD;
                    else if (i_last_candidate) n_state = prcm_pkg::S_COMMIT;
                end
            end
            prcm_pkg::S_FIND_RD: n_state = prcm_pkg::S_FIND_STEP;
            prcm_pkg::S_FIND_STEP: begin
                if (find_hit && (r_cur != r_start)) n_state = prcm_pkg::S_COMP_RD;
            end
            prcm_pkg::S_COMP_RD:   n_state = prcm_pkg::S_COMP_STEP;
            prcm_pkg::S_COMP_STEP: ;
            prcm_pkg::S_SIZE_A:    n_state = prcm_pkg::S_SIZE_B;
            prcm_pkg::S_SIZE_B:    n_state = prcm_pkg::S_SIZE_GET;
            prcm_pkg::S_SIZE_GET:  n_state = r_merge ? prcm_pkg::S_UNION : prcm_pkg::S_MUL;
            prcm_pkg::S_MUL:       n_state = prcm_pkg::S_PICK;
            prcm_pkg::S_PICK:      n_state = r_last ? prcm_pkg::S_COMMIT : prcm_pkg::S_IDLE;
            prcm_pkg::S_COMMIT:    n_state = prcm_pkg::S_FIND_RD;
            prcm_pkg::S_UNION: begin
                if (out_free) n_state = prcm_pkg::S_IDLE;
            end
            default:               n_state = prcm_pkg::S_CLEAR;
        endcase
        // end of a root walk: second endpoint next, or on to the sizes
        if (walk_done) begin
            n_state = (r_phase == prcm_pkg::PH_A) ? prcm_pkg::S_FIND_RD : prcm_pkg::S_SIZE_A;
        end
        if (i_cfg_we) n_state = prcm_pkg::S_CLEAR;
    end

    // datapath and memory control
    always_comb begin
        n_phase       = r_phase;
        n_merge       = r_merge;
        n_clr         = r_clr;
        n_node_cnt    = r_node_cnt;
        n_largest     = r_largest;
        n_run_pos     = r_run_pos;
        n_best_pos    = r_best_pos;
        n_out_valid   = r_out_valid && i_out_stall;
        n_a           = r_a;
        n_b           = r_b;
        n_last        = r_last;
        n_start       = r_start;
        n_cur         = r_cur;
        n_root_a      = r_root_a;
        n_root_b      = r_root_b;
        n_size_a      = r_size_a;
        n_size_b      = r_size_b;
        n_prod        = r_prod;
        n_best_a      = r_best_a;
        n_best_b      = r_best_b;
        n_best_prod   = r_best_prod;
        n_out_idx     = r_out_idx;
        n_out_merged  = r_out_merged;
        n_out_joined  = r_out_joined;
        n_out_largest = r_out_largest;
        n_out_prod    = r_out_prod;
        par_we        = 1'b0;
        par_waddr     = r_cur;
        par_wdata     = root_cur;
        par_raddr     = r_cur;
        cnt_we        = 1'b0;
        cnt_waddr     = r_root_a;
        cnt_wdata     = size_sum;
        cnt_raddr     = (r_state == prcm_pkg::S_SIZE_A) ? r_root_a : r_root_b;

        unique case (r_state)
            // every node its own root of size 1
            prcm_pkg::S_CLEAR: begin
                par_we    = 1'b1;
                par_waddr = r_clr;
                par_wdata = r_clr;
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = SW'(1);
                n_clr     = r_clr + NW'(1);
            end
            // capture a candidate beat
            prcm_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_a    = clip_a;
                    n_b    = clip_b;
                    n_last = i_last_candidate;
                    if (take_cand) begin
                        n_phase = prcm_pkg::PH_A;
                        n_merge = 1'b0;
                        n_start = clip_a;
                        n_cur   = clip_a;
                    end
                end
            end
            prcm_pkg::S_FIND_RD: ;
            // chase parents until a self link
            prcm_pkg::S_FIND_STEP: begin
                if (find_hit) begin
                    if (r_phase == prcm_pkg::PH_A) n_root_a = r_cur;
                    else                           n_root_b = r_cur;
                    n_cur = r_start;
                end else begin
                    par_raddr = par_rd;
                    n_cur     = par_rd;
                end
            end
            prcm_pkg::S_COMP_RD: ;
            // compression: point each node on the path at the root
            prcm_pkg::S_COMP_STEP: begin
                if (!comp_end) begin
                    par_we    = 1'b1;
                    par_raddr = par_rd;
                    n_cur     = par_rd;
                end
            end
            prcm_pkg::S_SIZE_A: ;
            prcm_pkg::S_SIZE_B:   n_size_a = cnt_rd;
            prcm_pkg::S_SIZE_GET: n_size_b = cnt_rd;
            prcm_pkg::S_MUL:      n_prod = PW'(r_size_a) * PW'(r_size_b);
            // keep the smallest product, earliest on a tie
            prcm_pkg::S_PICK: begin
                if ((r_run_pos == '0) || (r_prod < r_best_prod)) begin
                    n_best_prod = r_prod;
                    n_best_a    = r_a;
                    n_best_b    = r_b;
                    n_best_pos  = BPW'(r_run_pos);
                end
                n_run_pos = r_run_pos + RPW'(1);
            end
            prcm_pkg::S_COMMIT: begin
                n_merge = 1'b1;
                n_phase = prcm_pkg::PH_A;
                n_start = r_best_a;
                n_cur   = r_best_a;
            end
            // union by size and result beat
            prcm_pkg::S_UNION: begin
                if (out_free) begin
                    if (r_root_a != r_root_b) begin
                        par_we    = 1'b1;
                        cnt_we    = 1'b1;
                        if (r_size_b > r_size_a) begin
                            par_waddr = r_root_a;
                            par_wdata = r_root_b;
                            cnt_waddr = r_root_b;
                        end else begin
                            par_waddr = r_root_b;
                            par_wdata = r_root_a;
                            cnt_waddr = r_root_a;
                        end
                        n_out_joined = size_sum;
                        if (size_sum > r_largest) n_largest = size_sum;
                        n_out_largest = (size_sum > r_largest) ? size_sum : r_largest;
                    end else begin
                        n_out_joined  = r_size_a;
                        if (r_size_a > r_largest) n_largest = r_size_a;
                        n_out_largest = (r_size_a > r_largest) ? r_size_a : r_largest;
                    end
                    n_out_merged = (r_root_a != r_root_b);
                    n_out_idx    = r_best_pos;
                    n_out_prod   = r_best_prod;
                    n_out_valid  = 1'b1;
                    n_run_pos    = '0;
                    n_best_pos   = '0;
                    n_merge      = 1'b0;
                end
            end
            default: ;
        endcase

        // first walk finished: start on the second endpoint
        if (walk_done && (r_phase == prcm_pkg::PH_A)) begin
            n_phase = prcm_pkg::PH_B;
            n_start = node_b_sel;
            n_cur   = node_b_sel;
        end

        // node_count write reinitializes the forest
        if (i_cfg_we) begin
            n_node_cnt = cfg_sat;
            n_largest  = SW'(1);
            n_run_pos  = '0;
            n_best_pos = '0;
            n_merge    = 1'b0;
            n_clr      = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prcm_pkg::S_CLEAR;
            r_phase     <= prcm_pkg::PH_A;
            r_merge     <= 1'b0;
            r_clr       <= '0;
            r_node_cnt  <= SW'(MAX_NODES);
            r_largest   <= SW'(1);
            r_run_pos   <= '0;
            r_best_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_merge     <= n_merge;
            r_clr       <= n_clr;
            r_node_cnt  <= n_node_cnt;
            r_largest   <= n_largest;
            r_run_pos   <= n_run_pos;
            r_best_pos  <= n_best_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a           <= n_a;
        r_b           <= n_b;
        r_last        <= n_last;
        r_start       <= n_start;
        r_cur         <= n_cur;
        r_root_a      <= n_root_a;
        r_root_b      <= n_root_b;
        r_size_a      <= n_size_a;
        r_size_b      <= n_size_b;
        r_prod        <= n_prod;
        r_best_a      <= n_best_a;
        r_best_b      <= n_best_b;
        r_best_prod   <= n_best_prod;
        r_out_idx     <= n_out_idx;
        r_out_merged  <= n_out_merged;
        r_out_joined  <= n_out_joined;
        r_out_largest <= n_out_largest;
        r_out_prod    <= n_out_prod;
    end

    // output beat
    assign o_out_valid      = r_out_valid;
    assign o_chosen_index   = prcm_pkg::IDX_W'(r_out_idx);
    assign o_merged         = r_out_merged;
    assign o_joined_size    = prcm_pkg::SIZE_OUT_W'(r_out_joined);
    assign o_largest_size   = prcm_pkg::SIZE_OUT_W'(r_out_largest);
    assign o_chosen_product = prcm_pkg::PROD_OUT_W'(r_out_prod);

    // checks

    // a node_count write always starts the clearing pass
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == prcm_pkg::S_CLEAR) && o_in_stall)
        else $error("node_count write did not start clearing pass");

    // the run position never passes the candidate limit
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_pos <= RPW'(MAX_CANDIDATES))
        else $error("run position beyond candidate limit");

    // two distinct clusters never hold more nodes than are in use
    a_union_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prcm_pkg::S_UNION) && (r_root_a != r_root_b)
            |-> (PW'(r_size_a) + PW'(r_size_b)) <= PW'(r_node_cnt))
        else $error("merged cluster larger than node count");

    // a union with room at the output yields a result beat
    a_union_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prcm_pkg::S_UNION) && out_free && !i_cfg_we
            |=> r_out_valid && (r_out_largest >= r_out_joined))
        else $error("union did not produce a consistent result beat");

endmodule

`default_nettype wire

### design/prcm_ram.sv
// prcm_ram: simple one-write, one-read memory with registered read data.
// No dependencies; instantiated by product_rule_cluster_merge.
`timescale 1ns / 1ps
`default_nettype none

module prcm_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port (old data on a same-address write)
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### dv/testbench.sv
// testbench: self-checking bench for product_rule_cluster_merge, with a union-find
// predictor in a scoreboard class and random bursts, gaps and output stalls.
// Depends on prcm_pkg and the product_rule_cluster_merge RTL.
`timescale 1ns / 1ps

module testbench;

    // interface field widths
    localparam int END_W      = prcm_pkg::END_W;
    localparam int CFG_W      = prcm_pkg::CFG_W;
    localparam int IDX_W      = prcm_pkg::IDX_W;
    localparam int SIZE_OUT_W = prcm_pkg::SIZE_OUT_W;
    localparam int PROD_OUT_W = prcm_pkg::PROD_OUT_W;

    localparam int NODES_MAX     = 4096;
    localparam int CAND_MAX      = 64;
    localparam int SETTLE_CYCLES = 300;
    localparam int RUN_LIMIT_NS  = 18_000_000;

    // one result beat of the block
    typedef struct packed {
        logic [IDX_W-1:0]      chosen_index;
        logic                  merged;
        logic [SIZE_OUT_W-1:0] joined_size;
        logic [SIZE_OUT_W-1:0] largest_size;
        logic [PROD_OUT_W-1:0] chosen_product;
    } t_merge_result;

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } t_stall_mode;

    // union-find predictor and queue of expected merge results
    class merge_scoreboard;
        int unsigned   node_limit;
        int unsigned   up_link[NODES_MAX];
        int unsigned   member_count[NODES_MAX];
        int unsigned   biggest_cluster;
        bit [24:0]     keep_product;
        int unsigned   keep_a;
        int unsigned   keep_b;
        int unsigned   keep_pos;
        int unsigned   cand_pos;
        t_merge_result pending[$];
        int unsigned   faults;

        function new();
            faults = 0;
            set_nodes(13'(NODES_MAX));
        endfunction

        // register write: clamp and rebuild the forest
        function void set_nodes(logic [CFG_W-1:0] value);
            int unsigned v;
            v = value;
            if (v < 1) v = 1;
            if (v > NODES_MAX) v = NODES_MAX;
            node_limit = v;
            for (int i = 0; i < NODES_MAX; i++) begin
                up_link[i] = i;
                member_count[i] = 1;
            end
            biggest_cluster = 1;
            keep_product = '0;
            keep_a = 0;
            keep_b = 0;
            keep_pos = 0;
            cand_pos = 0;
        endfunction

        function int unsigned clip(int unsigned n);
            return (n >= node_limit) ? node_limit - 1 : n;
        endfunction

        // root lookup with path compression
        function int unsigned root_of(int unsigned n);
            int unsigned r;
            int unsigned c;
            int unsigned nx;
            r = n;
            while (up_link[r] != r) r = up_link[r];
            c = n;
            while (c != r) begin
                nx = up_link[c];
                up_link[c] = r;
                c = nx;
            end
            return r;
        endfunction

        // accepted candidate beat
        function void note_input(logic [END_W-1:0] end_a, logic [END_W-1:0] end_b,
                                 logic last);
            int unsigned   a;
            int unsigned   b;
            int unsigned   ra;
            int unsigned   rb;
            int unsigned   absorber;
            int unsigned   absorbed;
            int unsigned   joined;
            bit [24:0]     prod;
            bit            did_merge;
            t_merge_result exp;
            if (cand_pos < CAND_MAX) begin
                a = clip(end_a);
                b = clip(end_b);
                ra = root_of(a);
                rb = root_of(b);
                prod = 25'(member_count[ra] * member_count[rb]);
                if (cand_pos == 0 || prod < keep_product) begin
                    keep_product = prod;
                    keep_a = a;
                    keep_b = b;
                    keep_pos = cand_pos;
                end
                cand_pos++;
            end
            if (!last) return;

            // close the run: add the kept bond
            ra = root_of(keep_a);
            rb = root_of(keep_b);
            did_merge = 1'b0;
            if (ra != rb) begin
                absorber = ra;
                absorbed = rb;
                if (member_count[rb] > member_count[ra]) begin
                    absorber = rb;
                    absorbed = ra;
                end
                member_count[absorber] += member_count[absorbed];
                up_link[absorbed] = absorber;
                did_merge = 1'b1;
                joined = member_count[absorber];
            end else begin
                joined = member_count[ra];
            end
            if (joined > biggest_cluster) biggest_cluster = joined;

            exp.chosen_index   = IDX_W'(keep_pos);
            exp.merged         = did_merge;
            exp.joined_size    = SIZE_OUT_W'(joined);
            exp.largest_size   = SIZE_OUT_W'(biggest_cluster);
            exp.chosen_product = PROD_OUT_W'(keep_product);
            pending.insert(pending.size(), exp);
            cand_pos = 0;
            keep_pos = 0;
        endfunction

        // accepted result beat against the oldest expectation
        function void check_result(t_merge_result got);
            t_merge_result exp;
            if (pending.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: unexpected result beat idx=%0d merged=%0d joined=%0d",
                             $realtime, got.chosen_index, got.merged, got.joined_size);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                faults++;
                if (faults <= 10) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  chosen_index   exp %0d got %0d",
                             exp.chosen_index, got.chosen_index);
                    $display("  merged         exp %0d got %0d", exp.merged, got.merged);
                    $display("  joined_size    exp %0d got %0d",
                             exp.joined_size, got.joined_size);
                    $display("  largest_size   exp %0d got %0d",
                             exp.largest_size, got.largest_size);
                    $display("  chosen_product exp %0d got %0d",
                             exp.chosen_product, got.chosen_product);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_node_count;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [END_W-1:0]      i_end_a;
    logic [END_W-1:0]      i_end_b;
    logic                  i_last_candidate;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [IDX_W-1:0]      o_chosen_index;
    logic                  o_merged;
    logic [SIZE_OUT_W-1:0] o_joined_size;
    logic [SIZE_OUT_W-1:0] o_largest_size;
    logic [PROD_OUT_W-1:0] o_chosen_product;

    merge_scoreboard sb;
    t_stall_mode     stall_mode  = STALL_NONE;
    int unsigned     stall_timer = 0;
    int unsigned     burst_left  = 0;

    product_rule_cluster_merge #(
        .MAX_NODES      (NODES_MAX),
        .MAX_CANDIDATES (CAND_MAX)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_node_count     (i_node_count),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_end_a          (i_end_a),
        .i_end_b          (i_end_b),
        .i_last_candidate (i_last_candidate),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_chosen_index   (o_chosen_index),
        .o_merged         (o_merged),
        .o_joined_size    (o_joined_size),
        .o_largest_size   (o_largest_size),
        .o_chosen_product (o_chosen_product)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // beat monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_input(i_end_a, i_end_b, i_last_candidate);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result({o_chosen_index, o_merged, o_joined_size,
                             o_largest_size, o_chosen_product});
    end

    // receiver stall pattern, re-chosen whenever its timer runs out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_timer == 0) begin
                stall_mode  <= t_stall_mode'($urandom_range(0, 3));
                stall_timer <= $urandom_range(50, 400);
            end else begin
                stall_timer <= stall_timer - 1;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 1) == 0);
                default:     i_out_stall <= (stall_timer[4:0] < 5'd25);
            endcase
        end
    end

    // send one candidate beat; sender runs in bursts with random gaps
    task automatic send_beat(input logic [END_W-1:0] a, input logic [END_W-1:0] b,
                             input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_end_a          <= a;
        i_end_b          <= b;
        i_last_candidate <= last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // wait until every expected result is out and the block has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_nodes(input logic [CFG_W-1:0] value);
        i_cfg_we     <= 1'b1;
        i_node_count <= value;
        @(posedge i_clk);
        sb.set_nodes(value);
        i_cfg_we <= 1'b0;
    endtask

    // endpoint mostly inside a window, sometimes full width or at the edges
    function automatic logic [END_W-1:0] pick_node(int unsigned span);
        int unsigned lim;
        int unsigned roll;
        lim  = (span < sb.node_limit) ? span : sb.node_limit;
        roll = $urandom_range(0, 99);
        if (roll < 82) return END_W'($urandom_range(0, lim - 1));
        if (roll < 94) return END_W'($urandom_range(0, 4095));
        if (roll < 97) return END_W'(sb.node_limit - 1);
        return {END_W{1'b1}};
    endfunction

    // random runs; a few overflow the candidate limit
    task automatic run_phase(input int unsigned count, input int unsigned span);
        int unsigned done;
        int unsigned len;
        int unsigned roll;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)      len = $urandom_range(1, 6);
            else if (roll < 95) len = $urandom_range(7, 40);
            else                len = $urandom_range(60, 72);
            for (int k = 0; k < len; k++) begin
                send_beat(pick_node(span), pick_node(span), k == len - 1);
                if (k < CAND_MAX || k == len - 1) done++;
            end
        end
    endtask

    task automatic retune_and_run(input logic [CFG_W-1:0] value, input int unsigned span,
                                  input int unsigned count);
        drain();
        write_nodes(value);
        run_phase(count, span);
    endtask

    initial begin
        sb = new();
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_node_count     <= '0;
        i_in_valid       <= 1'b0;
        i_end_a          <= '0;
        i_end_b          <= '0;
        i_last_candidate <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: basic merge, self-loop, internal bond
        send_beat(12'd0, 12'd1, 1'b1);
        send_beat(12'd5, 12'd5, 1'b1);
        send_beat(12'd1, 12'd0, 1'b1);
        // product tie, earlier candidate kept
        send_beat(12'd0, 12'd2, 1'b0);
        send_beat(12'd3, 12'd4, 1'b0);
        send_beat(12'hFFF, 12'hFFF, 1'b1);
        // equal cluster sizes
        send_beat(12'd8, 12'd9, 1'b1);
        send_beat(12'd10, 12'd11, 1'b1);
        send_beat(12'd10, 12'd8, 1'b1);
        // field extremes and alternating bit patterns
        send_beat(12'hFFF, 12'd0, 1'b1);
        send_beat(12'hAAA, 12'h555, 1'b0);
        send_beat(12'h555, 12'hAAA, 1'b0);
        send_beat(12'h800, 12'h7FF, 1'b1);
        send_beat(12'd0, 12'hFFF, 1'b1);

        // random phases across register settings, extremes included
        run_phase(150, 48);
        retune_and_run(13'd1,    1,    60);
        retune_and_run(13'd2,    2,    60);
        retune_and_run(13'd0,    1,    40);
        retune_and_run(13'd16,   16,   150);
        retune_and_run(13'h1FFF, 64,   150);
        retune_and_run(13'd5000, 4096, 120);
        retune_and_run(13'd100,  100,  200);
        retune_and_run(13'd4096, 24,   150);
        retune_and_run(13'd3000, 512,  120);
        drain();

        if (sb.faults == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
design/prcm_pkg.sv
design/prcm_ram.sv
design/product_rule_cluster_merge.sv
dv/testbench.sv
